>>> rtl/calendar_date_normalize_epoch_macros.svh
// assertion macros for the calendar date normalizer checker
// no dependencies
`ifndef CALENDAR_DATE_NORMALIZE_EPOCH_MACROS_SVH
`define CALENDAR_DATE_NORMALIZE_EPOCH_MACROS_SVH

// same-cycle implication, disabled in reset
`define CDNE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cdne check failed");

// next-cycle implication, disabled in reset
`define CDNE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cdne check failed");

`endif

>>> rtl/cdne_pkg.sv
// shared types, microcode codes and calendar helpers for the date normalizer
// no dependencies
package cdne_pkg;

  localparam int PC_W = 3;

  // datapath operations
  localparam logic [2:0] OP_SUB400 = 3'd0;
  localparam logic [2:0] OP_FWD    = 3'd1;
  localparam logic [2:0] OP_BWD    = 3'd2;
  localparam logic [2:0] OP_FLAG   = 3'd3;
  localparam logic [2:0] OP_SAVE   = 3'd4;
  localparam logic [2:0] OP_MONTH  = 3'd5;
  localparam logic [2:0] OP_YEAR   = 3'd6;
  localparam logic [2:0] OP_EMIT   = 3'd7;

  // jump conditions
  localparam logic [2:0] C_ALWAYS = 3'd0;
  localparam logic [2:0] C_GE400  = 3'd1;
  localparam logic [2:0] C_DGTMD  = 3'd2;
  localparam logic [2:0] C_DLE0   = 3'd3;
  localparam logic [2:0] C_OOR    = 3'd4;
  localparam logic [2:0] C_MOGT1  = 3'd5;
  localparam logic [2:0] C_YRGT   = 3'd6;

  // program addresses
  localparam logic [PC_W-1:0] PC_MOD   = 3'd0;
  localparam logic [PC_W-1:0] PC_FWD   = 3'd1;
  localparam logic [PC_W-1:0] PC_BWD   = 3'd2;
  localparam logic [PC_W-1:0] PC_RANGE = 3'd3;
  localparam logic [PC_W-1:0] PC_SAVE  = 3'd4;
  localparam logic [PC_W-1:0] PC_MONTH = 3'd5;
  localparam logic [PC_W-1:0] PC_YEAR  = 3'd6;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd7;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic ge400;
    logic d_gt_md;
    logic d_le0;
    logic oor;
    logic mo_gt1;
    logic yr_gt;
  } stat_t;

  // leap test on year mod 400
  function automatic logic is_leap(input logic [11:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != 12'd100) && (ymod != 12'd200)
      && (ymod != 12'd300);
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m) inside
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> rtl/cdne_rom.sv
// microcode store: one control word per program step
// depends on cdne_pkg
module cdne_rom (
  input  logic [cdne_pkg::PC_W-1:0] pc,
  output cdne_pkg::ctrl_t           ctrl
);

  always_comb begin
    case (pc)
      cdne_pkg::PC_MOD:
        ctrl = '{cdne_pkg::OP_SUB400, cdne_pkg::C_GE400, cdne_pkg::PC_MOD};
      cdne_pkg::PC_FWD:
        ctrl = '{cdne_pkg::OP_FWD, cdne_pkg::C_DGTMD, cdne_pkg::PC_FWD};
      cdne_pkg::PC_BWD:
        ctrl = '{cdne_pkg::OP_BWD, cdne_pkg::C_DLE0, cdne_pkg::PC_BWD};
      cdne_pkg::PC_RANGE:
        ctrl = '{cdne_pkg::OP_FLAG, cdne_pkg::C_OOR, cdne_pkg::PC_EMIT};
      cdne_pkg::PC_SAVE:
        ctrl = '{cdne_pkg::OP_SAVE, cdne_pkg::C_ALWAYS, cdne_pkg::PC_MONTH};
      cdne_pkg::PC_MONTH:
        ctrl = '{cdne_pkg::OP_MONTH, cdne_pkg::C_MOGT1, cdne_pkg::PC_MONTH};
      cdne_pkg::PC_YEAR:
        ctrl = '{cdne_pkg::OP_YEAR, cdne_pkg::C_YRGT, cdne_pkg::PC_YEAR};
      default:
        ctrl = '{cdne_pkg::OP_EMIT, cdne_pkg::C_ALWAYS, cdne_pkg::PC_MOD};
    endcase
  end

endmodule

>>> rtl/cdne_dp.sv
// datapath: year, month, day walk registers, epoch day sum and result registers
// depends on cdne_pkg
module cdne_dp (
  input  logic               clk,
  input  logic               load,
  input  logic               exec,
  input  logic [2:0]         op,
  input  logic [11:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic signed [20:0] in_day,
  output cdne_pkg::stat_t    stat,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [19:0]        epoch_days,
  output logic               out_of_range
);

  logic signed [13:0] yr;
  logic [11:0]        ymod;
  logic [3:0]         mo;
  logic signed [20:0] dy;
  logic [19:0]        total;

  logic [11:0] ymod_inc;
  logic [11:0] ymod_dec;
  logic        leap_cur;
  logic        leap_dec;
  logic [3:0]  mo_dec;
  logic [4:0]  md_cur;
  logic [4:0]  md_back;
  logic [4:0]  md_prev;
  logic [3:0]  mo_sat;

  assign ymod_inc = (ymod == 12'd399) ? 12'd0 : ymod + 12'd1;
  assign ymod_dec = (ymod == 12'd0) ? 12'd399 : ymod - 12'd1;
  assign leap_cur = cdne_pkg::is_leap(ymod);
  assign leap_dec = cdne_pkg::is_leap(ymod_dec);
  assign mo_dec   = (mo == 4'd1) ? 4'd12 : mo - 4'd1;
  assign md_cur   = cdne_pkg::month_days(leap_cur, mo);
  assign md_back  = cdne_pkg::month_days((mo == 4'd1) ? leap_dec : leap_cur, mo_dec);
  assign md_prev  = cdne_pkg::month_days(leap_cur, mo - 4'd1);
  assign mo_sat   = (in_month == 4'd0) ? 4'd1 : ((in_month > 4'd12) ? 4'd12 : in_month);

  assign stat.ge400   = ymod >= 12'd400;
  assign stat.d_gt_md = dy > $signed({16'b0, md_cur});
  assign stat.d_le0   = dy <= 21'sd0;
  assign stat.oor     = (yr < 14'sd1970) || (yr > 14'sd4095);
  assign stat.mo_gt1  = mo > 4'd1;
  assign stat.yr_gt   = yr > 14'sd1970;

  assign epoch_days = total;

  always_ff @(posedge clk) begin
    if (load) begin
      yr   <= $signed({2'b00, in_year});
      ymod <= in_year;
      mo   <= mo_sat;
      dy   <= in_day;
    end else if (exec) begin
      case (op)
        cdne_pkg::OP_SUB400: begin
          ymod <= ymod - 12'd400;
        end
        cdne_pkg::OP_FWD: begin
          dy <= dy - $signed({16'b0, md_cur});
          if (mo == 4'd12) begin
            mo   <= 4'd1;
            yr   <= yr + 14'sd1;
            ymod <= ymod_inc;
          end else begin
            mo <= mo + 4'd1;
          end
        end
        cdne_pkg::OP_BWD: begin
          dy <= dy + $signed({16'b0, md_back});
          mo <= mo_dec;
          if (mo == 4'd1) begin
            yr   <= yr - 14'sd1;
            ymod <= ymod_dec;
          end
        end
        cdne_pkg::OP_FLAG: begin
          out_year     <= 12'd0;
          out_month    <= 4'd0;
          out_day      <= 5'd0;
          total        <= 20'd0;
          out_of_range <= 1'b1;
        end
        cdne_pkg::OP_SAVE: begin
          out_year     <= yr[11:0];
          out_month    <= mo;
          out_day      <= dy[4:0];
          total        <= 20'(dy[19:0] - 20'd1);
          out_of_range <= 1'b0;
        end
        cdne_pkg::OP_MONTH: begin
          mo    <= mo - 4'd1;
          total <= total + {15'b0, md_prev};
        end
        cdne_pkg::OP_YEAR: begin
          yr    <= yr - 14'sd1;
          ymod  <= ymod_dec;
          total <= total + (leap_dec ? 20'd366 : 20'd365);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/calendar_date_normalize_epoch.sv
// top level: microcode sequencer driving the date normalizer datapath
// depends on cdne_pkg, cdne_rom, cdne_dp
//
//  channel  | handshake             | fields
//  ---------+-----------------------+--------------------------------------------------
//  input    | start & !busy         | in_year, in_month, in_day
//  result   | done (one cycle)      | out_year, out_month, out_day, epoch_days,
//           |                       | out_of_range
//
// per item the sequencer reduces the year mod 400 (up to 10 subtractions), walks the
// day count a month at a time, checks the range, then adds the months before the
// result month and the years since 1970 into epoch_days, which out-of-range years skip
// each step of the eight-word program loop uses the shared datapath
// rst is synchronous and clears the sequencer; busy stays high until done pulses
// results cannot be stalled; a new item can be accepted in the cycle done pulses
module calendar_date_normalize_epoch (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic signed [20:0] in_day,
  output logic               done,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [19:0]        epoch_days,
  output logic               out_of_range
);

  logic [cdne_pkg::PC_W-1:0] pc;
  cdne_pkg::ctrl_t           ctrl;
  cdne_pkg::stat_t           stat;
  logic                      cond_ok;
  logic                      exec;
  logic                      load;

  cdne_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      cdne_pkg::C_ALWAYS: cond_ok = 1'b1;
      cdne_pkg::C_GE400:  cond_ok = stat.ge400;
      cdne_pkg::C_DGTMD:  cond_ok = stat.d_gt_md;
      cdne_pkg::C_DLE0:   cond_ok = stat.d_le0;
      cdne_pkg::C_OOR:    cond_ok = stat.oor;
      cdne_pkg::C_MOGT1:  cond_ok = stat.mo_gt1;
      cdne_pkg::C_YRGT:   cond_ok = stat.yr_gt;
      default:            cond_ok = 1'b0;
    endcase
  end

  assign load = start && !busy;
  assign exec = busy && cond_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pc   <= cdne_pkg::PC_MOD;
    end else begin
      done <= exec && (ctrl.op == cdne_pkg::OP_EMIT);
      if (load) begin
        busy <= 1'b1;
        pc   <= cdne_pkg::PC_MOD;
      end else if (busy) begin
        if (exec && (ctrl.op == cdne_pkg::OP_EMIT)) begin
          busy <= 1'b0;
        end
        pc <= cond_ok ? ctrl.target : pc + 3'd1;
      end
    end
  end

  cdne_dp u_dp (
    .clk          (clk),
    .load         (load),
    .exec         (exec),
    .op           (ctrl.op),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .stat         (stat),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .epoch_days   (epoch_days),
    .out_of_range (out_of_range)
  );

endmodule

>>> rtl/cdne_chk.sv
// port-level checker for the date normalizer, bound to the top level
// depends on calendar_date_normalize_epoch_macros.svh
`include "calendar_date_normalize_epoch_macros.svh"

module cdne_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic [19:0] epoch_days,
  input logic        out_of_range
);

  `CDNE_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `CDNE_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `CDNE_ASSERT_IMP(a_fell_done, clk, rst, $fell(busy), done)
  `CDNE_ASSERT_IMP(a_oor_zero, clk, rst, done && out_of_range,
    out_year == 12'd0 && out_month == 4'd0 && out_day == 5'd0 && epoch_days == 20'd0)
  `CDNE_ASSERT_IMP(a_valid_date, clk, rst, done && !out_of_range,
    out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1 && out_year >= 12'd1970)

endmodule

bind calendar_date_normalize_epoch cdne_chk u_chk (.*);

>>> verif/tb.sv
// testbench for calendar_date_normalize_epoch: directed and random dates are checked
// against a behavioral date normalizer and epoch day counter kept in this file
// depends on rtl/calendar_date_normalize_epoch.sv and the cdne_pkg package it uses
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EPOCH_YEAR = 1970;
  localparam int LAST_YEAR  = 4095;
  localparam int DRAIN_CYCLES = 40000;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] days;
    logic        oor;
  } date_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [11:0]        in_year = '0;
  logic [3:0]         in_month = '0;
  logic signed [20:0] in_day = '0;
  logic               done;
  logic [11:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [19:0]        epoch_days;
  logic               out_of_range;

  date_result_t pending_dates[$];
  int           mismatches = 0;
  bit           idle_on = 1'b1;

  calendar_date_normalize_epoch u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .done         (done),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .epoch_days   (epoch_days),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit leap_year(input int yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int month_length(input int yr, input int mo);
    case (mo)
      2:           return leap_year(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic date_result_t normalize_date(input logic [11:0] yr_in,
                                                  input logic [3:0] mo_in,
                                                  input logic signed [20:0] day_in);
    int yr;
    int mo;
    int dy;
    int total;
    date_result_t r;
    yr = int'(yr_in);
    mo = int'(mo_in);
    dy = int'(day_in);
    r = '0;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    while (dy > month_length(yr, mo)) begin
      dy -= month_length(yr, mo);
      mo++;
      if (mo > 12) begin
        mo = 1;
        yr++;
      end
    end
    while (dy <= 0) begin
      mo--;
      if (mo <= 0) begin
        mo = 12;
        yr--;
      end
      dy += month_length(yr, mo);
    end
    if (yr < EPOCH_YEAR || yr > LAST_YEAR) begin
      r.oor = 1'b1;
      return r;
    end
    total = 0;
    for (int k = EPOCH_YEAR; k < yr; k++) total += leap_year(k) ? 366 : 365;
    for (int k = 1; k < mo; k++) total += month_length(yr, k);
    total += dy - 1;
    r.year  = 12'(yr);
    r.month = 4'(mo);
    r.day   = 5'(dy);
    r.days  = 20'(total);
    return r;
  endfunction

  // random start gaps while waiting, junk on the fields when start is low
  task automatic send_date(input logic [11:0] yr, input logic [3:0] mo,
                           input logic signed [20:0] dy);
    forever begin
      if (idle_on && $urandom_range(99) < 21) begin
        start    <= 1'b0;
        in_year  <= 12'($urandom);
        in_month <= 4'($urandom);
        in_day   <= 21'($urandom);
      end else begin
        start    <= 1'b1;
        in_year  <= yr;
        in_month <= mo;
        in_day   <= dy;
      end
      @(posedge clk);
      if (start && !busy) break;
    end
    pending_dates.push_back(normalize_date(yr, mo, dy));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    date_result_t got;
    date_result_t want;
    if (!rst && done) begin
      got = {out_year, out_month, out_day, epoch_days, out_of_range};
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none,", $time,
                 " actual y=%0d m=%0d d=%0d days=%0d oor=%0d",
                 got.year, got.month, got.day, got.days, got.oor);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t mismatch: expected y=%0d m=%0d d=%0d days=%0d oor=%0d,",
                   $time, want.year, want.month, want.day, want.days, want.oor,
                   " actual y=%0d m=%0d d=%0d days=%0d oor=%0d",
                   got.year, got.month, got.day, got.days, got.oor);
        end
      end
    end
  end

  task automatic test_epoch_bounds();
    send_date(12'd1970, 4'd1, 21'sd1);
    send_date(12'd4095, 4'd12, 21'sd31);
    send_date(12'd4095, 4'd1, 21'sd365);
    send_date(12'd1969, 4'd12, 21'sd32);
    send_date(12'd2023, 4'd4, 21'sd31);
  endtask

  task automatic test_range_flag();
    send_date(12'd1970, 4'd1, 21'sd0);
    send_date(12'd4095, 4'd12, 21'sd32);
    send_date(12'd0, 4'd1, 21'sd1);
    send_date(12'd1970, 4'd12, -21'sd400);
  endtask

  task automatic test_month_saturation();
    send_date(12'd2000, 4'd0, 21'sd15);
    send_date(12'd2000, 4'd13, 21'sd15);
    send_date(12'd2000, 4'd15, 21'sd40);
  endtask

  task automatic test_leap_years();
    send_date(12'd2000, 4'd2, 21'sd29);
    send_date(12'd1900 + 12'd200, 4'd2, 21'sd29);
    send_date(12'd2024, 4'd2, 21'sd29);
    send_date(12'd2023, 4'd2, 21'sd29);
    send_date(12'd2024, 4'd3, -21'sd59);
  endtask

  task automatic test_day_extremes();
    send_date(12'd1970, 4'd1, 21'sh100000);
    send_date(12'd1970, 4'd1, 21'sd1048575);
    send_date(12'd0, 4'd1, 21'sd1048575);
    send_date(12'd3000, 4'd6, -21'sd700000);
  endtask

  task automatic test_random_dates();
    int i;
    int kind;
    int yr;
    int mo;
    int dy;
    for (i = 0; i < 80; i++) begin
      // a long run with no start gaps in the middle
      idle_on = (i < 30 || i >= 60);
      kind = $urandom_range(99);
      yr = $urandom_range(LAST_YEAR, EPOCH_YEAR);
      mo = $urandom_range(12, 1);
      dy = $urandom_range(31, 1);
      if (kind < 45) begin
        dy = int'($urandom_range(1200)) - 400;
      end else if (kind < 60) begin
        dy = $urandom_range(31, 1);
      end else if (kind < 70) begin
        mo = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 13);
        dy = int'($urandom_range(100)) - 30;
      end else if (kind < 78) begin
        yr = $urandom_range(LAST_YEAR, LAST_YEAR - 5);
        dy = $urandom_range(3000);
      end else if (kind < 86) begin
        yr = ($urandom_range(1) == 0) ? $urandom_range(EPOCH_YEAR - 1) :
                                        $urandom_range(EPOCH_YEAR - 1, EPOCH_YEAR - 8);
        dy = int'($urandom_range(4000)) - 1000;
      end else if (kind < 94) begin
        yr = $urandom_range(EPOCH_YEAR + 1, EPOCH_YEAR);
        dy = -int'($urandom_range(800));
      end else begin
        yr = $urandom_range(LAST_YEAR);
        mo = $urandom_range(15);
        dy = int'($urandom);
      end
      send_date(12'(yr), 4'(mo), 21'(dy));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_epoch_bounds();
    test_range_flag();
    drain_results();
    test_month_saturation();
    test_leap_years();
    test_day_extremes();
    drain_results();
    test_random_dates();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_dates.size() == 0) begin
      $display("** calendar_date_normalize_epoch: PASSED **");
    end else begin
      $display("** calendar_date_normalize_epoch: FAILED **");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("** calendar_date_normalize_epoch: FAILED **");
    $finish;
  end

endmodule
